>>> rtl/rzwarp_pkg.sv
package rzwarp_pkg;

  localparam int FrameWidth  = 320;
  localparam int FrameHeight = 240;

  localparam logic [2:0] RegZoom   = 3'd0;
  localparam logic [2:0] RegCos    = 3'd1;
  localparam logic [2:0] RegSin    = 3'd2;
  localparam logic [2:0] RegDamp   = 3'd3;
  localparam logic [2:0] RegCx     = 3'd4;
  localparam logic [2:0] RegCy     = 3'd5;
  localparam logic [2:0] RegAspect = 3'd6;
  localparam logic [2:0] RegWtotal = 3'd7;

  typedef struct packed {
    logic [8:0] pixel_x;
    logic [7:0] pixel_y;
    logic       map_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         weight_top_left;
    logic [7:0]         weight_top_right;
    logic [7:0]         weight_bottom_left;
    logic [7:0]         weight_bottom_right;
    logic signed [19:0] offset_delta;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        zoom_scale;
    logic signed [15:0] rotation_cosine;
    logic signed [15:0] rotation_sine;
    logic [15:0]        damping_factor;
    logic [12:0]        center_x_pos;
    logic [11:0]        center_y_pos;
    logic [14:0]        aspect_ratio;
    logic [7:0]         weight_total;
  } cfg_t;

  typedef enum logic [4:0] {
    OpLoad, OpDx, OpDy, OpNx1, OpNx2, OpNy1, OpNy2, OpSx, OpSy, OpDivStart,
    OpDivWait, OpBx, OpBy, OpWts, OpWtl, OpWtr, OpWbl, OpWbr, OpOff
  } op_e;

  typedef enum logic [1:0] {StIdle, StRun, StDiv, StOut} state_e;

  typedef struct packed {
    logic load;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

>>> rtl/rzwarp_ctrl.sv
module rzwarp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  rzwarp_pkg::sts_t sts_i,
  output rzwarp_pkg::cmd_t cmd_o
);
  rzwarp_pkg::state_e state_q, state_d;
  rzwarp_pkg::op_e    op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rzwarp_pkg::StIdle;
      op_q    <= rzwarp_pkg::OpLoad;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '{load: 1'b0, op: op_q};
    case (state_q)
      rzwarp_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = rzwarp_pkg::StRun;
          op_d       = rzwarp_pkg::OpDx;
        end
      end
      rzwarp_pkg::StRun: begin
        case (op_q)
          rzwarp_pkg::OpDivStart: begin
            op_d = rzwarp_pkg::OpDivWait;
            state_d = rzwarp_pkg::StDiv;
          end
          // park on a no-op so the offset step runs only once
          rzwarp_pkg::OpOff: begin
            state_d = rzwarp_pkg::StOut;
            op_d    = rzwarp_pkg::OpLoad;
          end
          default: op_d = rzwarp_pkg::op_e'(op_q + 5'd1);
        endcase
      end
      rzwarp_pkg::StDiv: begin
        if (sts_i.div_done) begin
          state_d = rzwarp_pkg::StRun;
          op_d    = rzwarp_pkg::OpBx;
        end
      end
      rzwarp_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = rzwarp_pkg::StIdle;
      end
      default: state_d = rzwarp_pkg::StIdle;
    endcase
  end
endmodule

>>> rtl/rzwarp_datapath.sv
module rzwarp_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rzwarp_pkg::cfg_t      cfg_i,
  input  rzwarp_pkg::in_item_t  in_i,
  input  rzwarp_pkg::cmd_t      cmd_i,
  output rzwarp_pkg::sts_t      sts_o,
  output rzwarp_pkg::out_item_t out_o
);
  localparam logic signed [57:0] XLo = 58'sd65536;
  localparam logic signed [57:0] XHi = 58'(rzwarp_pkg::FrameWidth - 2) <<< 16;
  localparam logic signed [57:0] YHi = 58'(rzwarp_pkg::FrameHeight - 2) <<< 16;

  rzwarp_pkg::in_item_t  in_q;
  rzwarp_pkg::out_item_t res_q;
  logic signed [57:0] dx_q, dy_q, acc_q, nx_q, ny_q, sx_q, bx_q, by_q;
  logic signed [57:0] prod_q;
  logic signed [57:0] xpos, ypos, bxd, byd;
  logic [15:0] aeff;
  logic [7:0]  fx, fy;
  logic [8:0]  ix, iy;
  logic [18:0] last_q, abs_off;
  // restoring divider for floor(ny*S / (8A))
  logic [47:0] rem_q;
  logic [47:0] quo_q;
  logic        neg_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [48:0] trial;
  logic [8:0]  m1, m2;
  logic [17:0] mm;
  logic [25:0] wprod;

  assign aeff = (cfg_i.aspect_ratio == '0) ? 16'd1 : {1'b0, cfg_i.aspect_ratio};
  assign fx = bx_q[15:8];
  assign fy = by_q[15:8];
  assign ix = bx_q[24:16];
  assign iy = by_q[24:16];
  assign xpos = 58'({in_q.pixel_x, 16'd0});
  assign ypos = 58'({in_q.pixel_y, 16'd0});
  assign bxd = sx_q - xpos;
  assign byd = acc_q - ypos;
  assign trial = {rem_q, quo_q[47]} - {30'd0, aeff, 3'd0};
  assign abs_off = 19'((iy * 19'(rzwarp_pkg::FrameWidth) + 19'(ix)) << 2);
  assign mm = m1 * m2;
  assign wprod = 26'(prod_q[17:0]) * 26'(cfg_i.weight_total);

  // each weight step prepares the product for the next weight
  always_comb begin
    m1 = 9'd256 - 9'(fx);
    m2 = 9'd256 - 9'(fy);
    case (cmd_i.op)
      rzwarp_pkg::OpWtl: m1 = 9'(fx);
      rzwarp_pkg::OpWtr: m2 = 9'(fy);
      rzwarp_pkg::OpWbl: begin
        m1 = 9'(fx);
        m2 = 9'(fy);
      end
      default: ;
    endcase
  end

  function automatic logic signed [57:0] clampv(logic signed [57:0] v,
                                                logic signed [57:0] hi);
    clampv = (v < XLo) ? XLo : ((v > hi) ? hi : v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.op == rzwarp_pkg::OpOff && !busy_q && cmd_i.load == 1'b0 &&
          sts_o.div_done == 1'b0)
        last_q <= abs_off;
      if (cmd_i.op == rzwarp_pkg::OpDivStart) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd48;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) busy_q <= 1'b0;
      end
    end
  end

  assign sts_o.div_done = (cmd_i.op == rzwarp_pkg::OpDivWait) && !busy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_i;
    if (busy_q) begin
      if (!trial[48]) begin
        rem_q <= trial[47:0];
        quo_q <= {quo_q[46:0], 1'b1};
      end else begin
        rem_q <= {rem_q[46:0], quo_q[47]};
        quo_q <= {quo_q[46:0], 1'b0};
      end
    end
    case (cmd_i.op)
      rzwarp_pkg::OpDx:
        dx_q <= 58'(($signed({1'b0, in_q.pixel_x, 4'd0}) -
                     $signed({1'b0, cfg_i.center_x_pos})) <<< 12);
      rzwarp_pkg::OpDy:
        dy_q <= 58'(($signed({2'b0, in_q.pixel_y, 4'd0}) -
                     $signed({2'b0, cfg_i.center_y_pos})) * $signed({1'b0, aeff}));
      rzwarp_pkg::OpNx1: acc_q <= 58'($signed(dx_q[26:0]) * cfg_i.rotation_cosine);
      rzwarp_pkg::OpNx2:
        nx_q <= (acc_q - 58'($signed(dy_q[28:0]) * cfg_i.rotation_sine)) >>> 14;
      rzwarp_pkg::OpNy1: acc_q <= 58'($signed(dx_q[26:0]) * cfg_i.rotation_sine);
      rzwarp_pkg::OpNy2:
        ny_q <= (acc_q + 58'($signed(dy_q[28:0]) * cfg_i.rotation_cosine)) >>> 14;
      rzwarp_pkg::OpSx:
        sx_q <= (58'($signed(nx_q[29:0]) * $signed({1'b0, cfg_i.zoom_scale})) >>> 15) +
                58'($signed({1'b0, cfg_i.center_x_pos, 12'd0}));
      rzwarp_pkg::OpSy:
        prod_q <= 58'($signed(ny_q[29:0]) * $signed({1'b0, cfg_i.zoom_scale}));
      rzwarp_pkg::OpDivStart: begin
        neg_q <= prod_q[57];
        quo_q <= 48'(prod_q[57] ? -prod_q : prod_q);
        rem_q <= '0;
      end
      rzwarp_pkg::OpDivWait: if (!busy_q) begin
        // floor for negative numerator: -(q + (r != 0))
        acc_q <= 58'(neg_q ? -($signed({1'b0, quo_q}) + 49'(rem_q != '0))
                           : $signed({1'b0, quo_q})) + 58'({cfg_i.center_y_pos, 12'd0});
      end
      rzwarp_pkg::OpBx:
        bx_q <= clampv(xpos + (58'($signed(bxd[31:0]) *
                  $signed({1'b0, cfg_i.damping_factor})) >>> 15), XHi);
      rzwarp_pkg::OpBy:
        by_q <= clampv(ypos + (58'($signed(byd[41:0]) *
                  $signed({1'b0, cfg_i.damping_factor})) >>> 15), YHi);
      rzwarp_pkg::OpWts, rzwarp_pkg::OpWtl, rzwarp_pkg::OpWtr, rzwarp_pkg::OpWbl,
      rzwarp_pkg::OpWbr: begin
        prod_q <= 58'(mm);
        case (cmd_i.op)
          rzwarp_pkg::OpWtl: res_q.weight_top_left     <= wprod[23:16];
          rzwarp_pkg::OpWtr: res_q.weight_top_right    <= wprod[23:16];
          rzwarp_pkg::OpWbl: res_q.weight_bottom_left  <= wprod[23:16];
          rzwarp_pkg::OpWbr: res_q.weight_bottom_right <= wprod[23:16];
          default: ;
        endcase
      end
      rzwarp_pkg::OpOff:
        res_q.offset_delta <= 20'({1'b0, abs_off} -
                                  {1'b0, (in_q.map_start ? 19'd0 : last_q)});
      default: ;
    endcase
  end

  always_comb begin
    out_o = res_q;
  end
endmodule

>>> rtl/rotozoom_warp_map_generator.sv
// each accepted item runs the rotate, scale, divide, damp, weight and offset steps before its result is valid
// the 48-step restoring divider takes most of the time spent on each item
// one item at a time, next item taken once the result is taken
// rst_ni async active low: config and control registers to defaults, previous offset zero
module rotozoom_warp_map_generator (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rzwarp_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rzwarp_pkg::out_item_t out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i
);
  rzwarp_pkg::cfg_t cfg_q;
  rzwarp_pkg::cmd_t cmd;
  rzwarp_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{16'd31130, 16'sd16382, 16'sd246, 16'd27853, 13'd2560, 12'd1920,
                 15'd4096, 8'd255};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rzwarp_pkg::RegZoom:   cfg_q.zoom_scale      <= cfg_data_i;
        rzwarp_pkg::RegCos:    cfg_q.rotation_cosine <= cfg_data_i;
        rzwarp_pkg::RegSin:    cfg_q.rotation_sine   <= cfg_data_i;
        rzwarp_pkg::RegDamp:   cfg_q.damping_factor  <= cfg_data_i;
        rzwarp_pkg::RegCx:     cfg_q.center_x_pos    <= cfg_data_i[12:0];
        rzwarp_pkg::RegCy:     cfg_q.center_y_pos    <= cfg_data_i[11:0];
        rzwarp_pkg::RegAspect: cfg_q.aspect_ratio    <= cfg_data_i[14:0];
        rzwarp_pkg::RegWtotal: cfg_q.weight_total    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  rzwarp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .sts_i(sts), .cmd_o(cmd)
  );

  rzwarp_datapath u_dp (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_i(in_data_i), .cmd_i(cmd), .sts_o(sts),
    .out_o(out_data_o)
  );
endmodule

>>> rtl/rzwarp_checker.sv
module rzwarp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i
);
  // one item in flight: no new item while a result is shown
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready during output");
  // a result cannot follow its item directly
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o) else $error("early result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
endmodule

bind rotozoom_warp_map_generator rzwarp_checker u_chk (.*);
